// ===== rtl/hpl_pkg.sv =====
package hpl_pkg;

  // configuration port
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] RegRefTemp     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegInitialTemp = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegAmbientTemp = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegPropGain    = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegIntGain     = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegDriveCoeff  = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegLossCoeff   = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegTimeStep    = CfgIdxW'(7);

  // drive clamp, 255.0 in q8.16
  localparam logic [23:0] DriveMaxQ = 24'hFF0000;

  typedef struct packed {
    logic signed [31:0] ref_temp;
    logic signed [31:0] initial_temp;
    logic signed [31:0] ambient_temp;
    logic signed [31:0] prop_gain;
    logic signed [31:0] int_gain;
    logic signed [31:0] drive_coeff;
    logic signed [31:0] loss_coeff;
    logic        [30:0] time_step;
  } cfg_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_PROP  = 3'd0,
    MUL_INT   = 3'd1,
    MUL_DRIVE = 3'd2,
    MUL_LOSS  = 3'd3,
    MUL_STEP  = 3'd4
  } mul_sel_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic     load;      // transaction taken: apply restart, form differences
    logic     mul_en;    // register a product
    mul_sel_e mul_sel;
    logic     acc_ld;    // keep first shifted product
    logic     drv_upd;   // sum and clamp the drive, update history
    logic     rate_upd;  // sum and saturate the plant rate
    logic     finish;    // update temperature and time, load result register
  } cmd_t;

  typedef struct packed {
    logic out_busy;      // result register full and not taken this cycle
  } status_t;

endpackage

// ===== rtl/hpl_if.sv =====
// input transaction: one closed-loop tick
interface hpl_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// result transaction
interface hpl_out_if;
  logic               valid;
  logic               ready;
  logic        [23:0] drive;
  logic signed [31:0] temperature;
  logic        [31:0] elapsed;

  modport source (output valid, output drive, output temperature, output elapsed,
                  input ready);
  modport sink   (input valid, input drive, input temperature, input elapsed,
                  output ready);
endinterface

// register write transaction
interface hpl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hpl_pkg::CfgIdxW-1:0] index;
  logic [31:0]                 wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/hpl_cfg_regs.sv =====
module hpl_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  hpl_cfg_if.sink       cfg_ch,
  output hpl_pkg::cfg_t cfg_o
);
  import hpl_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ch.ready = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegRefTemp:     cfg_d.ref_temp     = cfg_ch.wdata;
        RegInitialTemp: cfg_d.initial_temp = cfg_ch.wdata;
        RegAmbientTemp: cfg_d.ambient_temp = cfg_ch.wdata;
        RegPropGain:    cfg_d.prop_gain    = cfg_ch.wdata;
        RegIntGain:     cfg_d.int_gain     = cfg_ch.wdata;
        RegDriveCoeff:  cfg_d.drive_coeff  = cfg_ch.wdata;
        RegLossCoeff:   cfg_d.loss_coeff   = cfg_ch.wdata;
        RegTimeStep:    cfg_d.time_step    = cfg_ch.wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hpl_ctrl.sv =====
module hpl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  hpl_in_if.sink           in_ch,
  input  hpl_pkg::status_t status_i,
  output hpl_pkg::cmd_t    cmd_o
);
  import hpl_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MPROP = 9'b000000010,
    ST_MINT  = 9'b000000100,
    ST_DRIVE = 9'b000001000,
    ST_MDRV  = 9'b000010000,
    ST_MLOSS = 9'b000100000,
    ST_RATE  = 9'b001000000,
    ST_MSTEP = 9'b010000000,
    ST_TEMP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // sequence and command decode
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_PROP;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) state_d = ST_MPROP;
      end
      ST_MPROP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PROP;
        state_d       = ST_MINT;
      end
      ST_MINT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INT;
        cmd_o.acc_ld  = 1'b1;
        state_d       = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd_o.drv_upd = 1'b1;
        state_d       = ST_MDRV;
      end
      ST_MDRV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DRIVE;
        state_d       = ST_MLOSS;
      end
      ST_MLOSS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LOSS;
        cmd_o.acc_ld  = 1'b1;
        state_d       = ST_RATE;
      end
      ST_RATE: begin
        cmd_o.rate_upd = 1'b1;
        state_d        = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_STEP;
        state_d       = ST_TEMP;
      end
      ST_TEMP: begin
        // wait here while the previous result is still held
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/hpl_dp.sv =====
module hpl_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hpl_pkg::cfg_t    cfg_i,
  input  logic             restart_i,
  input  hpl_pkg::cmd_t    cmd_i,
  output hpl_pkg::status_t status_o,
  hpl_out_if.source        out_ch
);
  import hpl_pkg::*;

  // saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v[49:31] == {19{v[49]}}) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7FFFFFFF;
    end
    return r;
  endfunction

  function automatic logic signed [49:0] sx32(input logic signed [31:0] v);
    return $signed({{18{v[31]}}, v});
  endfunction

  function automatic logic signed [49:0] sx48(input logic signed [47:0] v);
    return $signed({{2{v[47]}}, v});
  endfunction

  // loop state
  logic signed [31:0] temp_q;
  logic        [23:0] last_drive_q;
  logic signed [31:0] last_error_q;
  logic        [31:0] sim_time_q;

  // working registers
  logic signed [31:0] err_q, diff_q, rate_q;
  logic        [23:0] drv_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] acc_q;

  // result register
  logic               out_valid_q;
  logic        [23:0] out_drive_q;
  logic signed [31:0] out_temp_q;
  logic        [31:0] out_time_q;

  logic signed [31:0] cur_temp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [47:0] prod_sh;
  logic signed [49:0] drv_sum;
  logic        [23:0] drv_clamp;
  logic signed [31:0] temp_next;
  logic        [31:0] time_next;

  // temperature this tick starts from
  assign cur_temp = restart_i ? cfg_i.initial_temp : temp_q;

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PROP: begin
        mul_a = err_q;
        mul_b = cfg_i.prop_gain;
      end
      MUL_INT: begin
        mul_a = cfg_i.int_gain;
        mul_b = last_error_q;
      end
      MUL_DRIVE: begin
        mul_a = cfg_i.drive_coeff;
        mul_b = $signed({8'b0, drv_q});
      end
      MUL_LOSS: begin
        mul_a = cfg_i.loss_coeff;
        mul_b = diff_q;
      end
      MUL_STEP: begin
        mul_a = rate_q;
        mul_b = $signed({1'b0, cfg_i.time_step});
      end
      default: begin
        mul_a = err_q;
        mul_b = cfg_i.prop_gain;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  // floor shift by 16 of the registered product
  assign prod_sh = prod_q[63:16];

  // drive sum and clamp to 0..255
  assign drv_sum = sx48(acc_q) + sx48(prod_sh) + $signed({26'b0, last_drive_q});
  always_comb begin
    if (drv_sum[49]) begin
      drv_clamp = '0;
    end else if (drv_sum > $signed({26'b0, DriveMaxQ})) begin
      drv_clamp = DriveMaxQ;
    end else begin
      drv_clamp = drv_sum[23:0];
    end
  end

  assign temp_next = sat32(sx32(temp_q) + sx48(prod_sh));
  assign time_next = sim_time_q + {1'b0, cfg_i.time_step};

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= sat32(sx32(cfg_i.ref_temp) - sx32(cur_temp));
      diff_q <= sat32(sx32(cfg_i.ambient_temp) - sx32(cur_temp));
    end
    if (cmd_i.mul_en)   prod_q <= mul_p;
    if (cmd_i.acc_ld)   acc_q  <= prod_sh;
    if (cmd_i.drv_upd)  drv_q  <= drv_clamp;
    if (cmd_i.rate_upd) rate_q <= sat32(sx48(acc_q) + sx48(prod_sh));
    if (cmd_i.finish) begin
      out_drive_q <= drv_q;
      out_temp_q  <= temp_next;
      out_time_q  <= time_next;
    end
  end

  // loop state, cleared by reset; restart loads the initial temperature and clears the rest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q       <= '0;
      last_drive_q <= '0;
      last_error_q <= '0;
      sim_time_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        temp_q <= cur_temp;
        if (restart_i) begin
          last_drive_q <= '0;
          last_error_q <= '0;
          sim_time_q   <= '0;
        end
      end
      if (cmd_i.drv_upd) begin
        last_drive_q <= drv_clamp;
        last_error_q <= err_q;
      end
      if (cmd_i.finish) begin
        temp_q     <= temp_next;
        sim_time_q <= time_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy  = out_valid_q && !out_ch.ready;
  assign out_ch.valid       = out_valid_q;
  assign out_ch.drive       = out_drive_q;
  assign out_ch.temperature = out_temp_q;
  assign out_ch.elapsed     = out_time_q;

endmodule

// ===== rtl/heater_pi_loop_with_plant_model_top.sv =====
// channel   dir   payload                          transaction when
// in_ch     in    restart                          valid && ready
// out_ch    out   drive, temperature, elapsed      valid && ready
// cfg_ch    in    index, wdata                     valid && ready (ready tied high)
//
// a sequencer steps five 32x32 products through one shared multiplier, with
// sum stages for drive, plant rate and temperature, and takes no new tick
// until the last one has finished its steps.
// a new tick is accepted once the sequencer is back in idle, also while the
// previous result still waits; a stalled result holds the sequencer in its
// last step. rst_ni clears config, loop state and control asynchronously.
module heater_pi_loop_with_plant_model_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hpl_in_if.sink    in_ch,
  hpl_out_if.source out_ch,
  hpl_cfg_if.sink   cfg_ch
);
  import hpl_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // register file
  hpl_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  // sequencer
  hpl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // arithmetic and loop state
  hpl_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (in_ch.restart),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_ch    (out_ch)
  );

endmodule
